>>> rtl/lmed_pkg.sv
// Shared types and constants for the list-mode event deframer.
// Used by lmed_parser, lmed_result_q and list_mode_event_deframer_top.
package lmed_pkg;

  localparam int unsigned MaxChannels = 16;
  localparam int unsigned MarkLen     = 10;

  localparam logic [15:0] ChanMask = 16'((32'd1 << MaxChannels) - 32'd1);

  localparam logic [31:0] SyncWord  = 32'hFFFF_FFFF;
  localparam logic [15:0] TimerTag  = 16'h4000;
  localparam int unsigned RtcBit    = 28;
  localparam int unsigned DummyBit  = 31;
  localparam logic [2:0]  BreakLen  = 3'd2;
  localparam logic [2:0]  RtcLen    = 3'd6;
  localparam logic [2:0]  DummyLen  = 3'd2;

  // "[LISTDATA]", first character at index 0
  localparam logic [0:MarkLen-1][7:0] MarkText = {
    8'h5B, 8'h4C, 8'h49, 8'h53, 8'h54, 8'h44, 8'h41, 8'h54, 8'h41, 8'h5D
  };

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_BREAK  = 6'b000010,
    PH_HEADER = 6'b000100,
    PH_RTC    = 6'b001000,
    PH_DUMMY  = 6'b010000,
    PH_VALUES = 6'b100000
  } phase_e;

  // word index taken from paddr[2]
  typedef enum logic {
    REG_CTRL = 1'b0
  } reg_addr_e;

  typedef struct packed {
    logic we;
    logic value;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic [15:0] value;
    logic        empty_event;
    logic        last;
    logic [31:0] event_count;
    logic [31:0] timer_count;
    logic [31:0] rtc_count;
  } result_t;

endpackage

>>> rtl/lmed_parser.sv
// Front end: accepts stream bytes, hunts the text marker, assembles header
// words and classifies them into results. Depends on lmed_pkg.
module lmed_parser import lmed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  output logic        expect_o,
  input  logic        byte_valid_i,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  logic                   expect_q;
  phase_e                 phase_q, phase_d, cur_phase, restart_phase;
  logic [0:MarkLen-1][7:0] win_q, win_d, cur_win, win_shift;
  logic [2:0]             cnt_q, cnt_d, cur_cnt, cnt_inc;
  logic [31:0]            hdr_q, hdr_d, cur_hdr, word_new;
  logic [15:0]            mask_q, mask_d, cur_mask, mask_left;
  logic [7:0]             low_q, low_d, cur_low;
  logic [31:0]            ev_q, ev_d, cur_ev;
  logic [31:0]            tm_q, tm_d, cur_tm;
  logic [31:0]            rtc_q, rtc_d, cur_rtc;
  logic [1:0]             idx;
  logic [3:0]             first_ch;
  logic                   fin;
  logic                   res_valid;

  assign expect_o      = expect_q;
  assign restart_phase = expect_q ? PH_HUNT : PH_HEADER;

  always_comb begin
    cur_phase = phase_q;
    cur_win   = win_q;
    cur_cnt   = cnt_q;
    cur_hdr   = hdr_q;
    cur_mask  = mask_q;
    cur_low   = low_q;
    cur_ev    = ev_q;
    cur_tm    = tm_q;
    cur_rtc   = rtc_q;
    // new file: restart before the byte is used
    if (start_of_file_i) begin
      cur_phase = restart_phase;
      cur_win   = '0;
      cur_cnt   = '0;
      cur_hdr   = '0;
      cur_mask  = '0;
      cur_low   = '0;
      cur_ev    = '0;
      cur_tm    = '0;
      cur_rtc   = '0;
    end
  end

  assign win_shift = {cur_win[1:MarkLen-1], data_byte_i};
  assign cnt_inc   = cur_cnt + 3'd1;
  assign idx       = cur_cnt[1:0];
  assign word_new  = ((idx == 2'd0) ? 32'h0 : cur_hdr) |
                     (32'(data_byte_i) << {idx, 3'b000});

  // lowest active channel
  always_comb begin
    first_ch = '0;
    for (int i = MaxChannels - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        first_ch = 4'(i);
      end
    end
  end
  assign mask_left = cur_mask & ~(16'h1 << first_ch);

  always_comb begin
    phase_d   = cur_phase;
    win_d     = cur_win;
    cnt_d     = cur_cnt;
    hdr_d     = cur_hdr;
    mask_d    = cur_mask;
    low_d     = cur_low;
    ev_d      = cur_ev;
    tm_d      = cur_tm;
    rtc_d     = cur_rtc;
    fin       = 1'b0;
    res_valid = 1'b0;
    res_o.channel     = '0;
    res_o.value       = '0;
    res_o.empty_event = 1'b0;
    res_o.last        = 1'b0;
    case (cur_phase)
      PH_HUNT: begin
        win_d = win_shift;
        if (win_shift == MarkText) begin
          phase_d = PH_BREAK;
          cnt_d   = '0;
        end
      end
      PH_BREAK: begin
        if (cnt_inc >= BreakLen) begin
          cnt_d   = '0;
          phase_d = PH_HEADER;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_RTC: begin
        if (cnt_inc >= RtcLen) begin
          cnt_d = '0;
          if (cur_hdr[DummyBit]) begin
            phase_d = PH_DUMMY;
          end else begin
            fin = 1'b1;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_DUMMY: begin
        if (cnt_inc >= DummyLen) begin
          fin = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_VALUES: begin
        if (cur_cnt == 3'd0) begin
          low_d = data_byte_i;
          cnt_d = 3'd1;
        end else begin
          cnt_d             = '0;
          mask_d            = mask_left;
          res_valid         = 1'b1;
          res_o.channel     = first_ch;
          res_o.value       = {data_byte_i, cur_low};
          res_o.last        = (mask_left == 16'h0);
          if (mask_left == 16'h0) begin
            ev_d    = cur_ev + 32'd1;
            phase_d = PH_HEADER;
          end
        end
      end
      default: begin
        // header word assembly, little-endian
        phase_d = PH_HEADER;
        hdr_d   = word_new;
        cnt_d   = {1'b0, idx} + 3'd1;
        if (idx == 2'd3) begin
          cnt_d = '0;
          if (word_new == SyncWord) begin
            // drop sync
          end else if (word_new[31:16] == TimerTag) begin
            tm_d = cur_tm + 32'd1;
          end else begin
            mask_d = word_new[15:0] & ChanMask;
            if (word_new[RtcBit]) begin
              rtc_d   = cur_rtc + 32'd1;
              phase_d = PH_RTC;
            end else if (word_new[DummyBit]) begin
              phase_d = PH_DUMMY;
            end else begin
              fin = 1'b1;
            end
          end
        end
      end
    endcase
    // prefix done: emit empty marker or move to values
    if (fin) begin
      cnt_d = '0;
      if (mask_d == 16'h0) begin
        ev_d              = cur_ev + 32'd1;
        phase_d           = PH_HEADER;
        res_valid         = 1'b1;
        res_o.empty_event = 1'b1;
        res_o.last        = 1'b1;
      end else begin
        phase_d = PH_VALUES;
      end
    end
    res_o.event_count = cur_ev + 32'd1;
    res_o.timer_count = tm_d;
    res_o.rtc_count   = rtc_d;
  end

  assign res_valid_o = byte_valid_i & res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b1;
      phase_q  <= PH_HUNT;
      win_q    <= '0;
      cnt_q    <= '0;
      hdr_q    <= '0;
      mask_q   <= '0;
      low_q    <= '0;
      ev_q     <= '0;
      tm_q     <= '0;
      rtc_q    <= '0;
    end else if (cfg_i.we) begin
      // restart parse position, keep counters
      expect_q <= cfg_i.value;
      phase_q  <= cfg_i.value ? PH_HUNT : PH_HEADER;
      win_q    <= '0;
      cnt_q    <= '0;
      hdr_q    <= '0;
      mask_q   <= '0;
      low_q    <= '0;
    end else if (byte_valid_i) begin
      phase_q <= phase_d;
      win_q   <= win_d;
      cnt_q   <= cnt_d;
      hdr_q   <= hdr_d;
      mask_q  <= mask_d;
      low_q   <= low_d;
      ev_q    <= ev_d;
      tm_q    <= tm_d;
      rtc_q   <= rtc_d;
    end
  end

  a_more_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last && !cfg_i.we |=> phase_q == PH_VALUES)
    else $error("non-final value did not keep the value phase");

  a_last_to_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last && !cfg_i.we |=> phase_q == PH_HEADER)
    else $error("final result did not return to header assembly");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.empty_event |->
      res_o.last && res_o.value == 16'h0 && res_o.channel == 4'h0)
    else $error("empty marker carries data or lacks last mark");

endmodule

>>> rtl/lmed_result_q.sv
// Back end: two-entry result queue that drives the output channel.
// Depends on lmed_pkg.
module lmed_result_q import lmed_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t din_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t dout_o
);

  result_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign space_o     = (cnt_q != 2'd2);
  assign dout_o      = mem_q[rd_q];
  assign cnt_d       = cnt_q + {1'b0, push_i} - {1'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

endmodule

>>> rtl/list_mode_event_deframer_top.sv
// List-mode event deframer: one byte accepted per cycle; the byte that
// completes a result has it written into the queue register by the
// combinational parser step. Throughput is one byte per cycle; the two-entry
// result queue absorbs output stalls, and the input stalls while two wait.
// Reset clears parser, counters and queue; text-marker hunt is enabled.
// Top level; depends on lmed_pkg, lmed_parser and lmed_result_q.
module list_mode_event_deframer_top import lmed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  channel_o,
  output logic [15:0] value_o,
  output logic        empty_event_o,
  output logic        last_o,
  output logic [31:0] event_count_o,
  output logic [31:0] timer_count_o,
  output logic [31:0] rtc_count_o
);

  cfg_t    cfg;
  logic    expect_hdr;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t dout;
  logic    space;

  assign pready = 1'b1;
  assign cfg.we    = psel & penable & pwrite & pready & (paddr[2] == REG_CTRL);
  assign cfg.value = pwdata[0];
  assign prdata    = (paddr[2] == REG_CTRL) ? {31'b0, expect_hdr} : 32'h0;

  assign in_ready_o = space;
  assign accept     = in_valid_i & in_ready_o;

  lmed_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .expect_o       (expect_hdr),
    .byte_valid_i   (accept),
    .data_byte_i    (data_byte_i),
    .start_of_file_i(start_of_file_i),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  lmed_result_q u_result_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .din_i      (res),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .dout_o     (dout)
  );

  assign channel_o     = dout.channel;
  assign value_o       = dout.value;
  assign empty_event_o = dout.empty_event;
  assign last_o        = dout.last;
  assign event_count_o = dout.event_count;
  assign timer_count_o = dout.timer_count;
  assign rtc_count_o   = dout.rtc_count;

endmodule
